FILE: rtl/core/sfs_pkg.sv
// Shared types and constants of the sensor frame scanner.
package sfs_pkg;

	// Frame bytes.
	localparam logic [7:0] HDR_FIRST  = 8'd253;
	localparam logic [7:0] HDR_SECOND = 8'd254;
	localparam logic [7:0] TRAILER    = 8'd255;

	// Input action codes.
	localparam logic ACT_BYTE = 1'b0;
	localparam logic ACT_SCAN = 1'b1;

	// Depths of the command queue and the result queue.
	localparam int CMDQ_DEPTH = 4;
	localparam int RESQ_DEPTH = 4;

	typedef enum logic {
		CMD_WRITE,
		CMD_SCAN
	} cmd_kind_t;

	// Work handed from the deframer to the table engine.
	typedef struct packed {
		cmd_kind_t  kind;
		logic [3:0] mux;
		logic [3:0] ch;
		logic [7:0] level;
	} cmd_t;

	// One result item.
	typedef struct packed {
		logic [2:0] mux_index;
		logic [2:0] channel;
		logic [7:0] level;
		logic       last;
	} res_t;

endpackage

FILE: rtl/core/sfs_fifo.sv
// Small register queue used between the scanner stages and on the result side.
module sfs_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             full,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	logic [WIDTH-1:0] store_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	// A transfer happens on each side only when that side allows it.
	assign full    = (count_q == CNT_FULL);
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = store_q[rd_ptr_q];

	// Entry storage needs no reset.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			store_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/core/sfs_front.sv
// Front end: serial deframer and classifier that issues table commands.
module sfs_front #(
	parameter int MUX_COUNT = 8,
	parameter int CHANNELS  = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          take,
	input  logic          action,
	input  logic [7:0]    rx_byte,
	output logic          cmd_push,
	output sfs_pkg::cmd_t cmd
);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_SYNC,
		PH_ADDR,
		PH_LEVEL,
		PH_TRAIL
	} phase_t;

	phase_t     phase_q;
	logic [7:0] addr_q;
	logic [7:0] level_q;
	logic       take_byte;
	logic       in_range;
	logic       frame_done;

	assign take_byte = take && (action == sfs_pkg::ACT_BYTE);

	// A finished frame only counts when its address lies inside the table.
	assign in_range   = (5'(addr_q[7:4]) < 5'(MUX_COUNT)) && (5'(addr_q[3:0]) < 5'(CHANNELS));
	assign frame_done = take_byte && (phase_q == PH_TRAIL) && (rx_byte == sfs_pkg::TRAILER)
	                    && in_range;

	// Scans always go to the back end; good frames become table writes.
	always_comb begin
		cmd_push  = (take && (action == sfs_pkg::ACT_SCAN)) || frame_done;
		cmd.kind  = (action == sfs_pkg::ACT_SCAN) ? sfs_pkg::CMD_SCAN : sfs_pkg::CMD_WRITE;
		cmd.mux   = addr_q[7:4];
		cmd.ch    = addr_q[3:0];
		cmd.level = level_q;
	end

	// Deframer state and captured bytes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			addr_q  <= '0;
			level_q <= '0;
		end else if (take_byte) begin
			unique case (phase_q)
				PH_IDLE: begin
					phase_q <= (rx_byte == sfs_pkg::HDR_FIRST) ? PH_SYNC : PH_IDLE;
				end
				PH_SYNC: begin
					phase_q <= (rx_byte == sfs_pkg::HDR_SECOND) ? PH_ADDR : PH_IDLE;
				end
				PH_ADDR: begin
					addr_q  <= rx_byte;
					phase_q <= PH_LEVEL;
				end
				PH_LEVEL: begin
					level_q <= rx_byte;
					phase_q <= PH_TRAIL;
				end
				PH_TRAIL: begin
					phase_q <= PH_IDLE;
				end
				default: begin
					phase_q <= PH_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: rtl/core/sfs_back.sv
// Back end: sensor and sent tables, table writes and the change scan.
module sfs_back #(
	parameter int MUX_COUNT = 8,
	parameter int CHANNELS  = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [63:0]   enable_mask,
	input  sfs_pkg::cmd_t cmd,
	input  logic          cmd_empty,
	output logic          cmd_pop,
	output logic          res_push,
	output sfs_pkg::res_t res,
	input  logic          res_full
);

	localparam int TABLE  = MUX_COUNT * CHANNELS;
	localparam int IDX_W  = (TABLE > 1) ? $clog2(TABLE) : 1;
	localparam int SCAN_N = (TABLE < 64) ? TABLE : 64;
	localparam logic [IDX_W-1:0] SCAN_LAST = IDX_W'(SCAN_N - 1);
	localparam logic [3:0]       COL_LAST  = 4'(CHANNELS - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FLUSH
	} state_t;

	logic [7:0]       sensor_mem [TABLE];
	logic [7:0]       sent_mem   [TABLE];
	logic [TABLE-1:0] sens_valid_q;
	logic [TABLE-1:0] sent_valid_q;

	state_t           state_q;
	logic             issue_q;
	logic [IDX_W-1:0] scan_idx_q;
	logic [3:0]       row_q;
	logic [3:0]       col_q;

	logic             valid_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [3:0]       row_s1;
	logic [3:0]       col_s1;
	logic [7:0]       sens_s1;
	logic [7:0]       sent_s1;
	logic             sens_ok_s1;
	logic             sent_ok_s1;

	logic             pend_v_q;
	sfs_pkg::res_t    pend_q;

	logic [IDX_W-1:0] wr_idx;
	logic             do_write;
	logic [7:0]       sens_lvl;
	logic [7:0]       sent_lvl;
	logic             hit;
	logic             adv;
	logic             rd_en;
	logic             sent_wr;

	// Command decode: a write goes straight into the sensor table.
	assign wr_idx   = IDX_W'(32'(cmd.mux) * CHANNELS + 32'(cmd.ch));
	assign cmd_pop  = (state_q == ST_IDLE) && !cmd_empty;
	assign do_write = cmd_pop && (cmd.kind == sfs_pkg::CMD_WRITE);

	// Entries never written read as zero.
	assign sens_lvl = sens_ok_s1 ? sens_s1 : '0;
	assign sent_lvl = sent_ok_s1 ? sent_s1 : '0;
	assign hit      = valid_s1 && enable_mask[6'(idx_s1)] && (sens_lvl != sent_lvl);

	// The scan pipe holds when a found entry cannot retire the pending result.
	assign adv     = (state_q == ST_SCAN) && !(hit && pend_v_q && res_full);
	assign rd_en   = adv && issue_q;
	assign sent_wr = adv && hit;

	// The pending result is released when the next hit arrives or the scan ends.
	always_comb begin
		res_push = pend_v_q && !res_full
		           && (((state_q == ST_SCAN) && hit) || (state_q == ST_FLUSH));
		res      = pend_q;
		res.last = (state_q == ST_FLUSH);
	end

	// Sensor table port: command writes, scan reads.
	always_ff @(posedge clk) begin
		if (do_write) begin
			sensor_mem[wr_idx] <= cmd.level;
		end
		if (rd_en) begin
			sens_s1 <= sensor_mem[scan_idx_q];
		end
	end

	// Sent table port: copy updates, scan reads.
	always_ff @(posedge clk) begin
		if (sent_wr) begin
			sent_mem[idx_s1] <= sens_lvl;
		end
		if (rd_en) begin
			sent_s1 <= sent_mem[scan_idx_q];
		end
	end

	// Scan stage payload and the pending result.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			idx_s1 <= scan_idx_q;
			row_s1 <= row_q;
			col_s1 <= col_q;
		end
		if (sent_wr) begin
			pend_q.mux_index <= row_s1[2:0];
			pend_q.channel   <= col_s1[2:0];
			pend_q.level     <= sens_lvl;
			pend_q.last      <= 1'b0;
		end
	end

	// Sequencer for writes and scans, with the table valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			issue_q      <= 1'b0;
			scan_idx_q   <= '0;
			row_q        <= '0;
			col_q        <= '0;
			valid_s1     <= 1'b0;
			sens_ok_s1   <= 1'b0;
			sent_ok_s1   <= 1'b0;
			pend_v_q     <= 1'b0;
			sens_valid_q <= '0;
			sent_valid_q <= '0;
		end else begin
			if (do_write) begin
				sens_valid_q[wr_idx] <= 1'b1;
			end
			if (sent_wr) begin
				sent_valid_q[idx_s1] <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_pop && (cmd.kind == sfs_pkg::CMD_SCAN)) begin
						state_q    <= ST_SCAN;
						issue_q    <= 1'b1;
						scan_idx_q <= '0;
						row_q      <= '0;
						col_q      <= '0;
						valid_s1   <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (adv) begin
						valid_s1 <= issue_q;
						if (issue_q) begin
							sens_ok_s1 <= sens_valid_q[scan_idx_q];
							sent_ok_s1 <= sent_valid_q[scan_idx_q];
							scan_idx_q <= scan_idx_q + 1'b1;
							if (col_q == COL_LAST) begin
								col_q <= '0;
								row_q <= row_q + 1'b1;
							end else begin
								col_q <= col_q + 1'b1;
							end
							if (scan_idx_q == SCAN_LAST) begin
								issue_q <= 1'b0;
							end
						end else begin
							state_q <= ST_FLUSH;
						end
						if (hit) begin
							pend_v_q <= 1'b1;
						end
					end
				end
				ST_FLUSH: begin
					if (!pend_v_q) begin
						state_q <= ST_IDLE;
					end else if (!res_full) begin
						pend_v_q <= 1'b0;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// A result is only pushed when the result queue has room.
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result pushed into a full queue");

	// The scan stage is empty whenever the sequencer is idle.
	a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !valid_s1)
		else $error("scan stage busy while idle");

	// Leaving the flush drains the pending result.
	a_flush_drains: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_FLUSH) && !res_full) |=> (!pend_v_q && (state_q == ST_IDLE)))
		else $error("pending result left after flush");

endmodule

FILE: rtl/core/sensor_frame_scanner.sv
// Sensor frame scanner: a byte or scan is accepted while the command queue has room.
// A table write passes through the command queue and is applied in the back end, one per cycle while it is idle.
// A scan covers min(MUX_COUNT*CHANNELS, 64) table entries, one table entry per cycle,
// held while a found entry waits on a full result queue; the last result appears when the scan ends.
// Reset is asynchronous: deframer idle, queues empty, enable_mask 1, tables read as zero
// through per-entry valid bits, so no clearing pass is needed.
module sensor_frame_scanner #(
	parameter int MUX_COUNT = 8,
	parameter int CHANNELS  = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input queue side
	input  logic        push,
	output logic        full,
	input  logic        action,
	input  logic [7:0]  rx_byte,
	// Result queue side
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  mux_index,
	output logic [2:0]  channel,
	output logic [7:0]  level,
	output logic        last,
	// Configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);

	localparam int CMD_W = $bits(sfs_pkg::cmd_t);
	localparam int RES_W = $bits(sfs_pkg::res_t);

	logic [63:0]      enable_mask_q;
	logic             take;
	logic             cmd_push;
	sfs_pkg::cmd_t    cmd_in;
	logic [CMD_W-1:0] cmdq_data;
	logic             cmdq_empty;
	logic             cmd_pop;
	logic             res_push;
	logic             res_full;
	sfs_pkg::res_t    res_in;
	logic [RES_W-1:0] resq_data;
	sfs_pkg::res_t    res_out;

	// Configuration register: register 0 occupies byte addresses 0 to 7.
	assign pready = 1'b1;
	assign prdata = (paddr[3] == 1'b0) ? enable_mask_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_mask_q <= 64'd1;
		end else if (psel && penable && pwrite && pready && (paddr[3] == 1'b0)) begin
			enable_mask_q <= pwdata;
		end
	end

	// An input transfer completes when the command queue has room.
	assign take = push && !full;

	sfs_front #(
		.MUX_COUNT (MUX_COUNT),
		.CHANNELS  (CHANNELS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.action   (action),
		.rx_byte  (rx_byte),
		.cmd_push (cmd_push),
		.cmd      (cmd_in)
	);

	// Command queue between the deframer and the table engine.
	sfs_fifo #(
		.WIDTH (CMD_W),
		.DEPTH (sfs_pkg::CMDQ_DEPTH)
	) u_cmdq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd_push),
		.wr_data (cmd_in),
		.rd_en   (cmd_pop),
		.rd_data (cmdq_data),
		.full    (full),
		.empty   (cmdq_empty)
	);

	sfs_back #(
		.MUX_COUNT (MUX_COUNT),
		.CHANNELS  (CHANNELS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.enable_mask (enable_mask_q),
		.cmd         (sfs_pkg::cmd_t'(cmdq_data)),
		.cmd_empty   (cmdq_empty),
		.cmd_pop     (cmd_pop),
		.res_push    (res_push),
		.res         (res_in),
		.res_full    (res_full)
	);

	// Result queue toward the consumer.
	sfs_fifo #(
		.WIDTH (RES_W),
		.DEPTH (sfs_pkg::RESQ_DEPTH)
	) u_resq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (res_in),
		.rd_en   (pop),
		.rd_data (resq_data),
		.full    (res_full),
		.empty   (empty)
	);

	assign res_out   = sfs_pkg::res_t'(resq_data);
	assign mux_index = res_out.mux_index;
	assign channel   = res_out.channel;
	assign level     = res_out.level;
	assign last      = res_out.last;

endmodule
